// ===== hw/rtl/mwsm_pkg.sv =====
// mwsm_pkg: shared sizes, types and codes for the maze wall set merger.
// Used by mwsm_cell and maze_wall_set_merger; depends on nothing.
`timescale 1ns / 1ps

package mwsm_pkg;

  localparam int GRID_SIZE = 32;                       // cells per side, 2..32
  localparam int NCELLS    = GRID_SIZE * GRID_SIZE;     // cells in the label ring
  localparam int LABEL_W   = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int COORD_W   = 5;                         // fixed field width
  localparam int IN_DATA_W  = 16;                       // row, col, direction + pad
  localparam int OUT_DATA_W = 16;                       // broke, row, col, complete + pad

  typedef logic [LABEL_W-1:0] label_t;
  typedef logic [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEEK,
    ST_MERGE,
    ST_EMIT
  } state_t;

  // Relabel command broadcast along the ring for one cycle.
  typedef struct packed {
    logic   en;
    label_t hi;
    label_t lo;
  } relabel_t;

endpackage

// ===== hw/rtl/mwsm_cell.sv =====
// mwsm_cell: one label cell of the rotating label ring.
// Depends on mwsm_pkg (label_t, relabel_t).
`timescale 1ns / 1ps

module mwsm_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  mwsm_pkg::label_t   init_label,  // label held after reset
  input  mwsm_pkg::label_t   prev_label,  // label of the upstream neighbor
  input  mwsm_pkg::relabel_t relabel,
  output mwsm_pkg::label_t   label
);

  mwsm_pkg::label_t label_r;
  mwsm_pkg::label_t label_nxt;

  // Take the neighbor's label every cycle, renamed if it carries the merged-away label.
  always_comb begin
    if (relabel.en && (prev_label == relabel.hi)) begin
      label_nxt = relabel.lo;
    end else begin
      label_nxt = prev_label;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      label_r <= init_label;
    end else begin
      label_r <= label_nxt;
    end
  end

  assign label = label_r;

endmodule

// ===== hw/rtl/maze_wall_set_merger.sv =====
// maze_wall_set_merger: top level of the Kruskal maze wall set merger.
// Depends on mwsm_pkg and mwsm_cell (ring of label cells).
`timescale 1ns / 1ps

// Usage
//   Input stream (in_*): one item names a cell (row, col) and a wall side to try.
//   Output stream (out_*): exactly one result item per input item, in order:
//   whether the wall was broken, where it sits in the vertical (out_tuser = 1) or
//   horizontal wall map, and whether the maze is now complete.
//   Labels live in a ring of NCELLS cells that rotates by one place every cycle;
//   the cell at the ring head is the only place labels are looked at.
// Sequencing
//   Cell outside the grid or no neighbor: the item is accepted, then emitted.
//   Otherwise the block waits for both labels to pass the ring head, then spends
//   a relabel cycle in which every cell renames the larger label as it shifts,
//   then emits once the output register is free. One item is in work at a time;
//   in_tready is high only when idle.
// Reset: synchronous, active low. Every cell takes its own index as label at once
//   and the merge count clears; no clearing pass is needed.
// Stalls: the result sits in an output register; a stalled receiver holds it there
//   and the next item may be taken and worked on, waiting only to emit.
// Completion: labels are always the minimum index of their set, so the grid is one
//   set exactly when NCELLS-1 merges have been done; the merge count tells this.

module maze_wall_set_merger (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: [4:0] cell_row, [9:5] cell_col, [11:10] direction, [15:12] zero
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mwsm_pkg::IN_DATA_W-1:0]  in_tdata,
  // out_tdata: [0] broke, [5:1] wall_row, [10:6] wall_col, [11] complete, [15:12] zero
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mwsm_pkg::OUT_DATA_W-1:0] out_tdata,
  // out_tuser: [0] wall_vertical
  output logic                            out_tuser
);

  localparam int NC = mwsm_pkg::NCELLS;
  localparam int LW = mwsm_pkg::LABEL_W;
  localparam int CW = mwsm_pkg::COORD_W;

  // ---------------------------------------------------------------- label ring
  mwsm_pkg::label_t   labels [NC];
  mwsm_pkg::relabel_t relabel;

  // Cell k takes from cell k+1, so the head (cell 0) sees labels in index order.
  for (genvar k = 0; k < NC; k++) begin : g_ring
    mwsm_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .init_label (LW'(k)),
      .prev_label (labels[(k + 1) % NC]),
      .relabel    (relabel),
      .label      (labels[k])
    );
  end

  // ---------------------------------------------------------------- state
  mwsm_pkg::state_t state_r, state_nxt;
  mwsm_pkg::label_t pos_r, pos_nxt;          // cell index now at the ring head
  mwsm_pkg::label_t ia_r, ia_nxt;            // chosen cell index
  mwsm_pkg::label_t ib_r, ib_nxt;            // neighbor cell index
  mwsm_pkg::label_t la_r, la_nxt;
  mwsm_pkg::label_t lb_r, lb_nxt;
  logic             fa_r, fa_nxt;            // label a captured
  logic             fb_r, fb_nxt;            // label b captured
  logic             broke_r, broke_nxt;
  logic             vert_r, vert_nxt;
  mwsm_pkg::coord_t wr_r, wr_nxt;
  mwsm_pkg::coord_t wc_r, wc_nxt;
  mwsm_pkg::label_t merge_count_r, merge_count_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_broke_r, out_broke_nxt;
  logic             out_vert_r, out_vert_nxt;
  mwsm_pkg::coord_t out_row_r, out_row_nxt;
  mwsm_pkg::coord_t out_col_r, out_col_nxt;
  logic             out_done_r, out_done_nxt;

  // ---------------------------------------------------------------- input decode
  mwsm_pkg::coord_t in_row, in_col, nb_row, nb_col, w_row, w_col;
  mwsm_pkg::dir_t   in_dir;
  logic             in_inside, nb_ok, w_vert;

  assign in_row = in_tdata[CW-1:0];
  assign in_col = in_tdata[2*CW-1:CW];
  assign in_dir = mwsm_pkg::dir_t'(in_tdata[2*CW+1:2*CW]);

  assign in_inside = ({1'b0, in_row} < (CW+1)'(mwsm_pkg::GRID_SIZE)) &&
                     ({1'b0, in_col} < (CW+1)'(mwsm_pkg::GRID_SIZE));

  always_comb begin
    nb_row = in_row;
    nb_col = in_col;
    w_row  = in_row;
    w_col  = in_col;
    w_vert = 1'b0;
    nb_ok  = 1'b0;
    unique case (in_dir)
      mwsm_pkg::DIR_LEFT: begin
        nb_ok  = (in_col != '0);
        nb_col = in_col - CW'(1);
        w_col  = in_col - CW'(1);
        w_vert = 1'b1;
      end
      mwsm_pkg::DIR_RIGHT: begin
        nb_ok  = (in_col != CW'(mwsm_pkg::GRID_SIZE - 1));
        nb_col = in_col + CW'(1);
        w_vert = 1'b1;
      end
      mwsm_pkg::DIR_UP: begin
        nb_ok  = (in_row != '0);
        nb_row = in_row - CW'(1);
        w_row  = in_row - CW'(1);
      end
      mwsm_pkg::DIR_DOWN: begin
        nb_ok  = (in_row != CW'(mwsm_pkg::GRID_SIZE - 1));
        nb_row = in_row + CW'(1);
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  // row * GRID_SIZE + col; only used for cells inside the grid
  function automatic mwsm_pkg::label_t cell_idx(mwsm_pkg::coord_t r, mwsm_pkg::coord_t c);
    logic [2*CW+LW-1:0] full;
    full = (2*CW+LW)'(r) * (2*CW+LW)'(mwsm_pkg::GRID_SIZE) + (2*CW+LW)'(c);
    return full[LW-1:0];
  endfunction

  // ---------------------------------------------------------------- control
  logic hit_a, hit_b, out_free;

  assign hit_a    = (pos_r == ia_r);
  assign hit_b    = (pos_r == ib_r);
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt       = state_r;
    pos_nxt         = (pos_r == LW'(NC - 1)) ? '0 : pos_r + LW'(1);
    ia_nxt          = ia_r;
    ib_nxt          = ib_r;
    la_nxt          = la_r;
    lb_nxt          = lb_r;
    fa_nxt          = fa_r;
    fb_nxt          = fb_r;
    broke_nxt       = broke_r;
    vert_nxt        = vert_r;
    wr_nxt          = wr_r;
    wc_nxt          = wc_r;
    merge_count_nxt = merge_count_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_broke_nxt   = out_broke_r;
    out_vert_nxt    = out_vert_r;
    out_row_nxt     = out_row_r;
    out_col_nxt     = out_col_r;
    out_done_nxt    = out_done_r;
    in_tready       = 1'b0;
    relabel.en      = 1'b0;
    relabel.hi      = (la_r > lb_r) ? la_r : lb_r;
    relabel.lo      = (la_r > lb_r) ? lb_r : la_r;

    unique case (state_r)
      mwsm_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ia_nxt    = cell_idx(in_row, in_col);
          ib_nxt    = cell_idx(nb_row, nb_col);
          vert_nxt  = w_vert;
          wr_nxt    = w_row;
          wc_nxt    = w_col;
          fa_nxt    = 1'b0;
          fb_nxt    = 1'b0;
          broke_nxt = 1'b0;
          state_nxt = (in_inside && nb_ok) ? mwsm_pkg::ST_SEEK : mwsm_pkg::ST_EMIT;
        end
      end
      mwsm_pkg::ST_SEEK: begin
        if (hit_a) begin
          la_nxt = labels[0];
          fa_nxt = 1'b1;
        end
        if (hit_b) begin
          lb_nxt = labels[0];
          fb_nxt = 1'b1;
        end
        if ((fa_r || hit_a) && (fb_r || hit_b)) begin
          state_nxt = mwsm_pkg::ST_MERGE;
        end
      end
      mwsm_pkg::ST_MERGE: begin
        relabel.en = (la_r != lb_r);
        broke_nxt  = (la_r != lb_r);
        if (la_r != lb_r) begin
          merge_count_nxt = merge_count_r + LW'(1);
        end
        state_nxt = mwsm_pkg::ST_EMIT;
      end
      mwsm_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_broke_nxt = broke_r;
          out_vert_nxt  = broke_r && vert_r;
          out_row_nxt   = broke_r ? wr_r : '0;
          out_col_nxt   = broke_r ? wc_r : '0;
          out_done_nxt  = (merge_count_r == LW'(NC - 1));
          state_nxt     = mwsm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mwsm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= mwsm_pkg::ST_IDLE;
      pos_r         <= '0;
      fa_r          <= 1'b0;
      fb_r          <= 1'b0;
      broke_r       <= 1'b0;
      merge_count_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      pos_r         <= pos_nxt;
      fa_r          <= fa_nxt;
      fb_r          <= fb_nxt;
      broke_r       <= broke_nxt;
      merge_count_r <= merge_count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ia_r        <= ia_nxt;
    ib_r        <= ib_nxt;
    la_r        <= la_nxt;
    lb_r        <= lb_nxt;
    vert_r      <= vert_nxt;
    wr_r        <= wr_nxt;
    wc_r        <= wc_nxt;
    out_broke_r <= out_broke_nxt;
    out_vert_r  <= out_vert_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
    out_done_r  <= out_done_nxt;
  end

  // ---------------------------------------------------------------- outputs
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_vert_r;
  assign out_tdata  = {(mwsm_pkg::OUT_DATA_W - 2*CW - 2)'(0),
                       out_done_r, out_col_r, out_row_r, out_broke_r};

  // ---------------------------------------------------------------- checks
  // Cell 0 always belongs to the set labeled zero.
  a_cell0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r == '0) |-> (labels[0] == '0))
    else $error("cell 0 label is not zero");

  a_merge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (merge_count_r <= LW'(NC - 1)))
    else $error("more merges than the grid allows");

  a_merge_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mwsm_pkg::ST_MERGE) |=> (state_r == mwsm_pkg::ST_EMIT))
    else $error("relabel cycle not followed by emit");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(state_r) == mwsm_pkg::ST_EMIT))
    else $error("result appeared outside emit");

  a_unbroken_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_broke_r) |-> (!out_vert_r && out_row_r == '0 && out_col_r == '0))
    else $error("unbroken wall reports a position");

endmodule

// ===== test/tb_maze_wall_set_merger.sv =====
`timescale 1ns / 1ps
// tb_maze_wall_set_merger: self-checking bench for the maze wall set merger.
// Keeps a shadow copy of the set labels to predict each result; needs mwsm_pkg and the RTL.

module tb_maze_wall_set_merger;

  localparam int IDLE_PCT     = 7;           // chance per cycle that a side idles
  localparam int RANDOM_TRIES = 424;
  localparam int SWEEP_ROWS   = 4;           // rows joined by the closing sweep
  localparam int QUIET_FIRST  = 200;         // item window with no idling on either side
  localparam int QUIET_LAST   = 330;
  localparam int DRAIN_CYCLES = mwsm_pkg::NCELLS + 8;  // drain wait after the queues empty: ring size plus slack

  // One wall attempt as it travels on in_tdata.
  typedef struct packed {
    mwsm_pkg::coord_t row;
    mwsm_pkg::coord_t col;
    mwsm_pkg::dir_t   dir;
  } wall_try_t;

  // One result item: out_tdata fields plus the out_tuser flag.
  typedef struct packed {
    logic             broke;
    logic             vertical;
    mwsm_pkg::coord_t wall_row;
    mwsm_pkg::coord_t wall_col;
    logic             complete;
  } wall_result_t;

  logic                            clk;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [mwsm_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [mwsm_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            out_tuser;

  wall_try_t        try_queue[$];              // wall attempts not yet offered
  wall_result_t     result_queue[$];           // predicted results awaiting the block
  mwsm_pkg::label_t set_tag[mwsm_pkg::NCELLS]; // shadow set label of every cell

  int     sent_count   = 0;
  int     taken_count  = 0;
  int     fault_count  = 0;
  longint cycle_count  = 0;
  longint cycle_budget = 0;
  logic   in_taken     = 1'b0;    // an item was accepted at the last rising edge

  maze_wall_set_merger u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Shadow of the block: try one wall, merge the two sets if it falls, and
  // report where the wall sits and whether every label has collapsed to zero.
  task automatic break_wall(input wall_try_t t, output wall_result_t res);
    int               r, c, nr, nc, wr, wc;
    logic             ok, vert;
    mwsm_pkg::label_t a, b, hi, lo;
    r    = t.row;
    c    = t.col;
    nr   = r;
    nc   = c;
    wr   = 0;
    wc   = 0;
    ok   = 1'b0;
    vert = 1'b0;
    res  = '0;
    // a cell outside the grid is ignored altogether
    if (r < mwsm_pkg::GRID_SIZE && c < mwsm_pkg::GRID_SIZE) begin
      case (t.dir)
        mwsm_pkg::DIR_LEFT: begin
          ok = (c > 0); nc = c - 1; vert = 1'b1; wr = r; wc = c - 1;
        end
        mwsm_pkg::DIR_RIGHT: begin
          ok = (c < mwsm_pkg::GRID_SIZE - 1); nc = c + 1; vert = 1'b1; wr = r; wc = c;
        end
        mwsm_pkg::DIR_UP: begin
          ok = (r > 0); nr = r - 1; wr = r - 1; wc = c;
        end
        default: begin
          ok = (r < mwsm_pkg::GRID_SIZE - 1); nr = r + 1; wr = r; wc = c;
        end
      endcase
      if (ok) begin
        a = set_tag[r * mwsm_pkg::GRID_SIZE + c];
        b = set_tag[nr * mwsm_pkg::GRID_SIZE + nc];
        if (a != b) begin
          hi = (a > b) ? a : b;
          lo = (a > b) ? b : a;
          foreach (set_tag[k]) if (set_tag[k] == hi) set_tag[k] = lo;
        end else begin
          ok = 1'b0;  // both cells already joined
        end
      end
    end
    // a wall left standing reports all zeros except the completion flag
    if (ok) begin
      res.broke    = 1'b1;
      res.vertical = vert;
      res.wall_row = mwsm_pkg::coord_t'(wr);
      res.wall_col = mwsm_pkg::coord_t'(wc);
    end
    res.complete = 1'b1;
    foreach (set_tag[k]) if (set_tag[k] != '0) res.complete = 1'b0;
  endtask

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fault_count++;
    end
  endtask

  task automatic add_try(input int r, input int c, input mwsm_pkg::dir_t d);
    wall_try_t t;
    t.row = mwsm_pkg::coord_t'(r);
    t.col = mwsm_pkg::coord_t'(c);
    t.dir = d;
    try_queue.push_back(t);
  endtask

  // Driver: inputs move on the falling edge. A new item is offered only once
  // the previous one was taken, so tvalid never drops while an item waits.
  always @(negedge clk) begin : driver
    wall_try_t t;
    logic      quiet_in, quiet_out;
    quiet_in  = (sent_count >= QUIET_FIRST && sent_count < QUIET_LAST);
    quiet_out = (taken_count >= QUIET_FIRST && taken_count < QUIET_LAST);
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (try_queue.size() != 0 && (quiet_in || $urandom_range(99) >= IDLE_PCT)) begin
        t = try_queue.pop_front();
        in_tdata   <= {4'b0, t.dir, t.col, t.row};
        in_tvalid  <= 1'b1;
        sent_count <= sent_count + 1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= rst_n && (quiet_out || $urandom_range(99) >= IDLE_PCT);
  end

  // Monitor: everything is sampled on the rising edge. A result leaving the
  // block is checked before the item accepted at the same edge is predicted.
  always @(posedge clk) begin : monitor
    wall_try_t    seen;
    wall_result_t want, got;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        taken_count <= taken_count + 1;
        got.broke    = out_tdata[0];
        got.wall_row = out_tdata[5:1];
        got.wall_col = out_tdata[10:6];
        got.complete = out_tdata[11];
        got.vertical = out_tuser;
        if (result_queue.size() == 0) begin
          $error("result item with no attempt pending: tdata %h tuser %b",
                 out_tdata, out_tuser);
          fault_count++;
        end else begin
          want = result_queue.pop_front();
          check_field("broke", want.broke, got.broke);
          check_field("wall_vertical", want.vertical, got.vertical);
          check_field("wall_row", want.wall_row, got.wall_row);
          check_field("wall_col", want.wall_col, got.wall_col);
          check_field("complete", want.complete, got.complete);
        end
      end
      if (in_tvalid && in_tready) begin
        seen.row = in_tdata[4:0];
        seen.col = in_tdata[9:5];
        seen.dir = mwsm_pkg::dir_t'(in_tdata[11:10]);
        break_wall(seen, want);
        result_queue.push_back(want);
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_budget != 0 && cycle_count > cycle_budget) begin
      $display("maze_wall_set_merger: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    int pick, side, edge_pos;
    foreach (set_tag[k]) set_tag[k] = mwsm_pkg::label_t'(k);

    // Directed: grid edges, each side, walls already open, all-ones and
    // alternating coordinates.
    add_try(0, 0, mwsm_pkg::DIR_LEFT);                // no neighbor
    add_try(0, 0, mwsm_pkg::DIR_UP);                  // no neighbor
    add_try(mwsm_pkg::GRID_SIZE - 1, mwsm_pkg::GRID_SIZE - 1, mwsm_pkg::DIR_RIGHT); // no neighbor
    add_try(mwsm_pkg::GRID_SIZE - 1, mwsm_pkg::GRID_SIZE - 1, mwsm_pkg::DIR_DOWN);  // no neighbor
    add_try(0, 0, mwsm_pkg::DIR_RIGHT);
    add_try(0, 1, mwsm_pkg::DIR_LEFT);                // same set now
    add_try(0, 0, mwsm_pkg::DIR_DOWN);
    add_try(1, 0, mwsm_pkg::DIR_UP);                  // same set now
    add_try(1, 0, mwsm_pkg::DIR_RIGHT);               // (1,1) joins via a third path
    add_try(0, 1, mwsm_pkg::DIR_DOWN);                // closes a loop: same set
    add_try(mwsm_pkg::GRID_SIZE - 1, mwsm_pkg::GRID_SIZE - 1, mwsm_pkg::DIR_LEFT);
    add_try(mwsm_pkg::GRID_SIZE - 1, mwsm_pkg::GRID_SIZE - 1, mwsm_pkg::DIR_UP);
    add_try(mwsm_pkg::GRID_SIZE - 2, mwsm_pkg::GRID_SIZE - 2, mwsm_pkg::DIR_DOWN);
    add_try(mwsm_pkg::GRID_SIZE - 2, mwsm_pkg::GRID_SIZE - 2, mwsm_pkg::DIR_RIGHT); // same set
    add_try(0, 1, mwsm_pkg::DIR_RIGHT);               // big set swallows (0,2)
    add_try(10, 21, mwsm_pkg::DIR_RIGHT);
    add_try(21, 10, mwsm_pkg::DIR_DOWN);
    add_try(21, 10, mwsm_pkg::DIR_LEFT);
    add_try(10, 21, mwsm_pkg::DIR_UP);
    add_try(5, mwsm_pkg::GRID_SIZE - 1, mwsm_pkg::DIR_DOWN);
    add_try(mwsm_pkg::GRID_SIZE - 1, 5, mwsm_pkg::DIR_RIGHT);
    add_try(mwsm_pkg::GRID_SIZE - 1, 0, mwsm_pkg::DIR_LEFT);  // no neighbor
    add_try(0, mwsm_pkg::GRID_SIZE - 1, mwsm_pkg::DIR_UP);    // no neighbor

    // Random walls anywhere, with some pokes at the outer border.
    for (int i = 0; i < RANDOM_TRIES; i++) begin
      pick = $urandom_range(99);
      if (pick < 85) begin
        add_try($urandom_range(31), $urandom_range(31),
                mwsm_pkg::dir_t'($urandom_range(3)));
      end else begin
        side     = $urandom_range(3);
        edge_pos = $urandom_range(mwsm_pkg::GRID_SIZE - 1);
        case (mwsm_pkg::dir_t'(side))
          mwsm_pkg::DIR_LEFT:  add_try(edge_pos, 0, mwsm_pkg::DIR_LEFT);
          mwsm_pkg::DIR_RIGHT: add_try(edge_pos, mwsm_pkg::GRID_SIZE - 1, mwsm_pkg::DIR_RIGHT);
          mwsm_pkg::DIR_UP:    add_try(0, edge_pos, mwsm_pkg::DIR_UP);
          default:             add_try(mwsm_pkg::GRID_SIZE - 1, edge_pos, mwsm_pkg::DIR_DOWN);
        endcase
      end
    end

    // Joining sweep: the first rows joined left to right, then joined to each
    // other down the first column, so large sets get merged.
    for (int r = 0; r < SWEEP_ROWS; r++)
      for (int c = 0; c < mwsm_pkg::GRID_SIZE - 1; c++) add_try(r, c, mwsm_pkg::DIR_RIGHT);
    for (int r = 0; r < SWEEP_ROWS - 1; r++) add_try(r, 0, mwsm_pkg::DIR_DOWN);

    // A few more random walls at the end.
    for (int i = 0; i < 6; i++)
      add_try($urandom_range(31), $urandom_range(31), mwsm_pkg::dir_t'($urandom_range(3)));

    // each item can wait a full ring turn plus receiver stalls
    cycle_budget = longint'(try_queue.size()) * (mwsm_pkg::NCELLS + 3) * 4 + 100000;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (try_queue.size() != 0 || in_tvalid) @(posedge clk);
    while (result_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (result_queue.size() != 0) begin
      $error("%0d predicted results never arrived", result_queue.size());
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("maze_wall_set_merger: match");
    end else begin
      $display("maze_wall_set_merger: mismatch");
    end
    $finish;
  end

endmodule
